[hdl/lj_pfv_pkg.sv]
// ----------------------------------------------------------------------------
// lj_pfv_pkg
// Shared types, widths and arithmetic helpers for the Lennard-Jones pair block.
// ----------------------------------------------------------------------------
package lj_pfv_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int IDX_W  = $clog2(MAX_PARTICLES);
    localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
    localparam int POS_W  = 24;
    localparam int BOX_W  = 23;
    localparam int CUT_W  = 24;
    localparam int FRC_W  = 32;
    localparam int VIR_W  = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQ  = 2'd1;

    localparam logic [BOX_W-1:0] BOX_RESET = 23'd2621440;
    localparam logic [CUT_W-1:0] CUT_RESET = 24'd409600;

    localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] K24_LIM = 64'hFFFF_FFFF_FFFF_FFFF / 24;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLR, ST_LI, ST_LI2, ST_LJ, ST_LJ2, ST_MI, ST_ABS,
        ST_SQ1, ST_SQ2, ST_SQ3, ST_SQ4, ST_DIV, ST_MQ, ST_MQD, ST_ACC,
        ST_OR, ST_OE
    } t_state;

    typedef enum logic [2:0] {
        M_SQ, M_CUBE, M_SIX, M_T, M_FX, M_FY
    } t_mph;

    // saturating multiply by 24
    function automatic logic [63:0] mulk24(input logic [63:0] a);
        logic [63:0] r;
        r = (a << 4) + (a << 3);
        if (a > K24_LIM) r = U64_MAX;
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)       r = 32'sh7FFF_FFFF;
        else if (v < -34'sd2147483648) r = 32'sh8000_0000;
        else                           r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
        logic signed [39:0] r;
        if (v > 42'sd549755813887)       r = 40'sh7F_FFFF_FFFF;
        else if (v < -42'sd549755813888) r = 40'sh80_0000_0000;
        else                             r = v[39:0];
        return r;
    endfunction

endpackage

[hdl/lj_pfv_ram.sv]
// ----------------------------------------------------------------------------
// lj_pfv_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lj_pfv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hdl/lj_pair_force_virial.sv]
// ----------------------------------------------------------------------------
// lj_pair_force_virial
// Lennard-Jones pair forces and virial in a periodic 2D box.
// ----------------------------------------------------------------------------
// Usage:
//   Load particles one per cycle: a transaction is taken when start is high
//   and busy is low. Items beyond MAX_PARTICLES are dropped. The item with
//   i_last_particle set starts the compute; busy stays high until the last
//   result has been sent.
//   Compute: a clearing sweep over the force RAM, then each active pair i<j
//   runs a sequencer: memory reads, minimum image, squares and, for pairs
//   inside the cutoff, a 64-step restoring divider for 1/r^2 and six 64x64
//   Q.32 products on one shared 32x32 multiplier.
//   Particle i's force is held in registers over its row while j's entry in
//   the force RAM is read, updated and written back.
//   Results: one per particle (RAM read, then emit),
//   each marked by o_valid for one cycle; the virial rides on the last one.
//   The receiver cannot stall. Configuration writes are always ready and
//   are meant for idle time only.
//   Reset clears the control state and restores the configuration
//   registers; the RAM contents need no clearing.
// ----------------------------------------------------------------------------
module lj_pair_force_virial (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [lj_pfv_pkg::POS_W-1:0]     i_pos_x,
    input  logic signed [lj_pfv_pkg::POS_W-1:0]     i_pos_y,
    input  logic                                    i_active,
    input  logic                                    i_last_particle,
    output logic                                    o_valid,
    output logic [lj_pfv_pkg::IDX_W-1:0]            o_particle_index,
    output logic signed [lj_pfv_pkg::FRC_W-1:0]     o_force_x,
    output logic signed [lj_pfv_pkg::FRC_W-1:0]     o_force_y,
    output logic signed [lj_pfv_pkg::VIR_W-1:0]     o_virial,
    output logic                                    o_last_result,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [lj_pfv_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lj_pfv_pkg::CFG_DAT_W-1:0]        i_cfg_data
);
    import lj_pfv_pkg::*;

    localparam int PW = 2 * POS_W + 1;
    localparam int FW = 2 * FRC_W;

    t_state r_state, n_state;
    t_mph   r_mph, n_mph;

    logic [BOX_W-1:0] r_box;
    logic [CUT_W-1:0] r_cut;
    logic [CNT_W-1:0] r_cnt, n_cnt, r_i, n_i, r_j, n_j, r_k, n_k;

    logic signed [POS_W-1:0] r_xi, n_xi, r_yi, n_yi;
    logic signed [FRC_W-1:0] r_fxi, n_fxi, r_fyi, n_fyi, r_fxj, n_fxj, r_fyj, n_fyj;
    logic signed [POS_W:0]   r_dx, n_dx, r_dy, n_dy;
    logic signed [POS_W+1:0] r_mx, n_mx, r_my, n_my;
    logic [POS_W:0]          r_adx, n_adx, r_ady, n_ady;
    logic                    r_sx, n_sx, r_sy, n_sy;
    logic [49:0]             r_s, n_s;
    logic [50:0]             r_rem, n_rem;
    logic [63:0]             r_q, n_q, r_inv2, n_inv2, r_inv6, n_inv6;
    logic [63:0]             r_ma, n_ma, r_mb, n_mb, r_prod, n_prod, r_acc, n_acc;
    logic                    r_sat, n_sat;
    logic [2:0]              r_mstep, n_mstep;
    logic [5:0]              r_dcnt, n_dcnt;
    logic [63:0]             r_emag, n_emag;
    logic                    r_eneg, n_eneg;
    logic signed [41:0]      r_vp, n_vp;
    logic signed [32:0]      r_fx, n_fx, r_fy, n_fy;
    logic signed [VIR_W-1:0] r_vir, n_vir;

    // RAM ports
    logic             pr_we;
    logic [IDX_W-1:0] pr_waddr, pr_raddr;
    logic [PW-1:0]    pr_wdata, pr_rdata;
    logic             fr_we;
    logic [IDX_W-1:0] fr_waddr, fr_raddr;
    logic [FW-1:0]    fr_wdata, fr_rdata;

    lj_pfv_ram #(.WIDTH(PW), .DEPTH(MAX_PARTICLES)) u_pos_ram (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(pr_waddr), .i_wdata(pr_wdata),
        .i_raddr(pr_raddr), .o_rdata(pr_rdata)
    );

    lj_pfv_ram #(.WIDTH(FW), .DEPTH(MAX_PARTICLES)) u_force_ram (
        .i_clk(i_clk), .i_we(fr_we), .i_waddr(fr_waddr), .i_wdata(fr_wdata),
        .i_raddr(fr_raddr), .o_rdata(fr_rdata)
    );

    // shared 32x32 multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    always_comb begin
        mul_a = r_mstep[1] ? r_ma[31:0] : r_ma[63:32];
        mul_b = r_mstep[0] ? r_mb[31:0] : r_mb[63:32];
        if (r_state == ST_SQ1) begin
            mul_a = 32'(r_adx);
            mul_b = 32'(r_adx);
        end else if (r_state == ST_SQ2) begin
            mul_a = 32'(r_ady);
            mul_b = 32'(r_ady);
        end
    end

    // accumulator updates for one interacting pair
    logic signed [FRC_W-1:0] fxi_new, fyi_new, fxj_new, fyj_new;
    logic signed [VIR_W-1:0] vir_new;
    assign fxi_new = sat32(34'(r_fxi) + 34'(r_fx));
    assign fyi_new = sat32(34'(r_fyi) + 34'(r_fy));
    assign fxj_new = sat32(34'(r_fxj) - 34'(r_fx));
    assign fyj_new = sat32(34'(r_fyj) - 34'(r_fy));
    assign vir_new = sat40(42'(r_vir) + r_vp);

    // minimum image on a raw difference
    function automatic logic signed [POS_W+1:0] min_img(input logic signed [POS_W:0] d,
                                                        input logic [BOX_W-1:0] len);
        logic [POS_W:0]          a;
        logic signed [POS_W+1:0] la;
        logic signed [POS_W+1:0] r;
        a  = d[POS_W] ? POS_W'(0) - d : d;
        la = $signed({3'b000, len}) - $signed({1'b0, a});
        r  = (POS_W+2)'(d);
        if ({1'b0, a, 1'b0} > {4'b0000, len}) begin
            r = (d > 0) ? -la : la;
        end
        return r;
    endfunction

    // clamp a Q.16 pair-force magnitude and apply its sign
    function automatic logic signed [32:0] pforce(input logic [63:0] m, input logic neg);
        logic [32:0] c;
        c = (m > 64'h8000_0000) ? 33'h0_8000_0000 : m[32:0];
        return neg ? -$signed(c) : $signed(c);
    endfunction

    logic [63:0] p2, emag_w, vm_full;
    logic [47:0] vm;
    logic        eneg_w;
    logic [64:0] add_w;
    logic [50:0] dtry;
    logic [63:0] q_next;
    assign p2      = r_acc[63] ? U64_MAX : {r_acc[62:0], 1'b0};
    assign eneg_w  = p2 < r_inv6;
    assign emag_w  = eneg_w ? r_inv6 - p2 : p2 - r_inv6;
    assign vm_full = mulk24(r_emag) >> 16;
    assign vm      = (vm_full > 64'h100_0000_0000) ? 48'h100_0000_0000 : vm_full[47:0];
    assign add_w   = (r_mstep == 3'd4) ? {1'b0, r_acc} + {33'b0, r_prod[63:32]}
                                       : {1'b0, r_acc} + {1'b0, r_prod};
    assign dtry    = {r_rem[49:0], 1'b1};
    assign q_next  = {r_q[62:0], (dtry >= {1'b0, r_s})};

    // next state and datapath
    always_comb begin
        n_state = r_state; n_mph = r_mph;
        n_cnt = r_cnt; n_i = r_i; n_j = r_j; n_k = r_k;
        n_xi = r_xi; n_yi = r_yi; n_fxi = r_fxi; n_fyi = r_fyi;
        n_fxj = r_fxj; n_fyj = r_fyj; n_dx = r_dx; n_dy = r_dy;
        n_mx = r_mx; n_my = r_my; n_adx = r_adx; n_ady = r_ady;
        n_sx = r_sx; n_sy = r_sy; n_s = r_s; n_rem = r_rem; n_q = r_q;
        n_inv2 = r_inv2; n_inv6 = r_inv6; n_ma = r_ma; n_mb = r_mb;
        n_prod = r_prod; n_acc = r_acc; n_sat = r_sat; n_mstep = r_mstep;
        n_dcnt = r_dcnt; n_emag = r_emag; n_eneg = r_eneg;
        n_vp = r_vp; n_fx = r_fx; n_fy = r_fy; n_vir = r_vir;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (r_cnt < CNT_W'(MAX_PARTICLES)) n_cnt = r_cnt + 1'b1;
                    if (i_last_particle) begin
                        n_k = '0;
                        n_state = ST_CLR;
                    end
                end
            end
            ST_CLR: begin
                n_k = r_k + 1'b1;
                if (r_k == r_cnt - 1'b1) begin
                    n_i = '0;
                    n_vir = '0;
                    n_state = ST_LI;
                end
            end
            ST_LI: begin
                if (r_i == r_cnt) begin
                    n_k = '0;
                    n_state = ST_OR;
                end else begin
                    n_state = ST_LI2;
                end
            end
            ST_LI2: begin
                n_xi  = pr_rdata[2*POS_W-1:POS_W];
                n_yi  = pr_rdata[POS_W-1:0];
                n_fxi = fr_rdata[FW-1:FRC_W];
                n_fyi = fr_rdata[FRC_W-1:0];
                n_j   = r_i + 1'b1;
                if (pr_rdata[PW-1]) begin
                    n_state = ST_LJ;
                end else begin
                    n_i = r_i + 1'b1;   // drop inactive row
                    n_state = ST_LI;
                end
            end
            ST_LJ: begin
                if (r_j == r_cnt) begin
                    n_i = r_i + 1'b1;
                    n_state = ST_LI;
                end else begin
                    n_state = ST_LJ2;
                end
            end
            ST_LJ2: begin
                n_fxj = fr_rdata[FW-1:FRC_W];
                n_fyj = fr_rdata[FRC_W-1:0];
                n_dx  = (POS_W+1)'(r_xi) - (POS_W+1)'($signed(pr_rdata[2*POS_W-1:POS_W]));
                n_dy  = (POS_W+1)'(r_yi) - (POS_W+1)'($signed(pr_rdata[POS_W-1:0]));
                if (pr_rdata[PW-1]) begin
                    n_state = ST_MI;
                end else begin
                    n_j = r_j + 1'b1;
                    n_state = ST_LJ;
                end
            end
            ST_MI: begin
                n_mx = min_img(r_dx, r_box);
                n_my = min_img(r_dy, r_box);
                n_state = ST_ABS;
            end
            ST_ABS: begin
                n_sx  = r_mx[POS_W+1];
                n_sy  = r_my[POS_W+1];
                n_adx = r_mx[POS_W+1] ? (POS_W+1)'(-r_mx) : (POS_W+1)'(r_mx);
                n_ady = r_my[POS_W+1] ? (POS_W+1)'(-r_my) : (POS_W+1)'(r_my);
                n_state = ST_SQ1;
            end
            ST_SQ1: begin
                n_prod = mul_p;
                n_state = ST_SQ2;
            end
            ST_SQ2: begin
                n_s = r_prod[49:0];
                n_prod = mul_p;
                n_state = ST_SQ3;
            end
            ST_SQ3: begin
                n_s = r_s + r_prod[49:0];
                n_state = ST_SQ4;
            end
            ST_SQ4: begin
                if (r_s >= {10'b0, r_cut, 16'b0}) begin
                    n_j = r_j + 1'b1;
                    n_state = ST_LJ;
                end else begin
                    n_rem = '0;
                    n_q = '0;
                    n_dcnt = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem = (dtry >= {1'b0, r_s}) ? dtry - {1'b0, r_s} : dtry;
                n_q = q_next;
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == 6'd63) begin
                    n_inv2 = q_next;
                    n_ma = q_next;
                    n_mb = q_next;
                    n_mph = M_SQ;
                    n_mstep = '0;
                    n_state = ST_MQ;
                end
            end
            ST_MQ: begin
                n_mstep = r_mstep + 1'b1;
                case (r_mstep)
                    3'd0: n_prod = mul_p;
                    3'd1: begin
                        n_acc = {r_prod[31:0], 32'b0};
                        n_sat = |r_prod[63:32];
                        n_prod = mul_p;
                    end
                    3'd2, 3'd3: begin
                        n_acc = add_w[63:0];
                        n_sat = r_sat | add_w[64];
                        n_prod = mul_p;
                    end
                    default: begin
                        n_acc = (r_sat | add_w[64]) ? U64_MAX : add_w[63:0];
                        n_state = ST_MQD;
                    end
                endcase
            end
            ST_MQD: begin
                n_mstep = '0;
                n_state = ST_MQ;
                case (r_mph)
                    M_SQ: begin
                        n_ma = r_acc;
                        n_mb = r_inv2;
                        n_mph = M_CUBE;
                    end
                    M_CUBE: begin
                        n_inv6 = r_acc;
                        n_ma = r_acc;
                        n_mb = r_acc;
                        n_mph = M_SIX;
                    end
                    M_SIX: begin
                        n_eneg = eneg_w;
                        n_emag = emag_w;
                        n_ma = emag_w;
                        n_mb = r_inv2;
                        n_mph = M_T;
                    end
                    M_T: begin
                        n_vp = r_eneg ? -$signed({1'b0, vm[40:0]})
                                      : $signed({1'b0, vm[40:0]});
                        n_ma = mulk24(r_acc);
                        n_mb = 64'(r_adx);
                        n_mph = M_FX;
                    end
                    M_FX: begin
                        n_fx = pforce(r_acc, r_eneg ^ r_sx);
                        n_mb = 64'(r_ady);
                        n_mph = M_FY;
                    end
                    default: begin
                        n_fy = pforce(r_acc, r_eneg ^ r_sy);
                        n_state = ST_ACC;
                    end
                endcase
            end
            ST_ACC: begin
                n_fxi = fxi_new;
                n_fyi = fyi_new;
                n_vir = vir_new;
                n_j = r_j + 1'b1;
                n_state = ST_LJ;
            end
            ST_OR: begin
                n_state = ST_OE;
            end
            ST_OE: begin
                n_k = r_k + 1'b1;
                if (r_k == r_cnt - 1'b1) begin
                    n_cnt = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_OR;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs and memory ports
    always_comb begin
        busy     = (r_state != ST_IDLE);
        pr_we    = 1'b0;
        pr_waddr = r_cnt[IDX_W-1:0];
        pr_wdata = {i_active, i_pos_x, i_pos_y};
        pr_raddr = r_i[IDX_W-1:0];
        fr_we    = 1'b0;
        fr_waddr = r_j[IDX_W-1:0];
        fr_wdata = {fxj_new, fyj_new};
        fr_raddr = r_i[IDX_W-1:0];
        o_valid  = 1'b0;
        case (r_state)
            ST_IDLE: pr_we = start && (r_cnt < CNT_W'(MAX_PARTICLES));
            ST_CLR: begin
                fr_we    = 1'b1;
                fr_waddr = r_k[IDX_W-1:0];
                fr_wdata = '0;
            end
            ST_LJ: begin
                pr_raddr = r_j[IDX_W-1:0];
                fr_raddr = r_j[IDX_W-1:0];
                if (r_j == r_cnt) begin
                    // retire row i
                    fr_we    = 1'b1;
                    fr_waddr = r_i[IDX_W-1:0];
                    fr_wdata = {r_fxi, r_fyi};
                end
            end
            ST_ACC:  fr_we = 1'b1;
            ST_OR:   fr_raddr = r_k[IDX_W-1:0];
            ST_OE:   o_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_cfg_ready      = 1'b1;
    assign o_particle_index = r_k[IDX_W-1:0];
    assign o_force_x        = fr_rdata[FW-1:FRC_W];
    assign o_force_y        = fr_rdata[FRC_W-1:0];
    assign o_last_result    = (r_k == r_cnt - 1'b1);
    assign o_virial         = o_last_result ? r_vir : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_box   <= BOX_RESET;
            r_cut   <= CUT_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_BOX_LENGTH: r_box <= i_cfg_data[BOX_W-1:0];
                    REG_CUTOFF_SQ:  r_cut <= i_cfg_data[CUT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mph <= n_mph; r_i <= n_i; r_j <= n_j; r_k <= n_k;
        r_xi <= n_xi; r_yi <= n_yi; r_fxi <= n_fxi; r_fyi <= n_fyi;
        r_fxj <= n_fxj; r_fyj <= n_fyj; r_dx <= n_dx; r_dy <= n_dy;
        r_mx <= n_mx; r_my <= n_my; r_adx <= n_adx; r_ady <= n_ady;
        r_sx <= n_sx; r_sy <= n_sy; r_s <= n_s; r_rem <= n_rem; r_q <= n_q;
        r_inv2 <= n_inv2; r_inv6 <= n_inv6; r_ma <= n_ma; r_mb <= n_mb;
        r_prod <= n_prod; r_acc <= n_acc; r_sat <= n_sat; r_mstep <= n_mstep;
        r_dcnt <= n_dcnt; r_emag <= n_emag; r_eneg <= n_eneg;
        r_vp <= n_vp; r_fx <= n_fx; r_fy <= n_fy; r_vir <= n_vir;
    end

endmodule
